### src/sm83_subset_instruction_executor_macros.svh
`ifndef SM83_SUBSET_INSTRUCTION_EXECUTOR_MACROS_SVH
`define SM83_SUBSET_INSTRUCTION_EXECUTOR_MACROS_SVH

// same-cycle implication on clk, off while arst_n is low
`define SM83_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, off while arst_n is low
`define SM83_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/sm83_pkg.sv
`default_nettype none

package sm83_pkg;

	localparam logic [7:0] FLAG_Z = 8'h80;
	localparam logic [7:0] FLAG_N = 8'h40;
	localparam logic [7:0] FLAG_H = 8'h20;
	localparam logic [7:0] FLAG_C = 8'h10;
	localparam logic [15:0] HIGH_PAGE = 16'hFF00;

	localparam logic [1:0] WK_NONE = 2'd0;
	localparam logic [1:0] WK_BYTE = 2'd1;
	localparam logic [1:0] WK_WORD = 2'd2;

	localparam logic [7:0] OP_NOP     = 8'h00;
	localparam logic [7:0] OP_DEC_B   = 8'h05;
	localparam logic [7:0] OP_LD_B_N  = 8'h06;
	localparam logic [7:0] OP_INC_C   = 8'h0C;
	localparam logic [7:0] OP_LD_C_N  = 8'h0E;
	localparam logic [7:0] OP_LD_DE   = 8'h11;
	localparam logic [7:0] OP_INC_DE  = 8'h13;
	localparam logic [7:0] OP_RLA     = 8'h17;
	localparam logic [7:0] OP_LD_A_DE = 8'h1A;
	localparam logic [7:0] OP_JR_NZ   = 8'h20;
	localparam logic [7:0] OP_LD_HL   = 8'h21;
	localparam logic [7:0] OP_LDI     = 8'h22;
	localparam logic [7:0] OP_INC_HL  = 8'h23;
	localparam logic [7:0] OP_JR_Z    = 8'h28;
	localparam logic [7:0] OP_LD_SP   = 8'h31;
	localparam logic [7:0] OP_LDD     = 8'h32;
	localparam logic [7:0] OP_DEC_A   = 8'h3D;
	localparam logic [7:0] OP_LD_A_N  = 8'h3E;
	localparam logic [7:0] OP_LD_C_A  = 8'h4F;
	localparam logic [7:0] OP_ST_HL   = 8'h77;
	localparam logic [7:0] OP_LD_A_E  = 8'h7B;
	localparam logic [7:0] OP_XOR_A   = 8'hAF;
	localparam logic [7:0] OP_POP_BC  = 8'hC1;
	localparam logic [7:0] OP_PUSH_BC = 8'hC5;
	localparam logic [7:0] OP_RET     = 8'hC9;
	localparam logic [7:0] OP_PREFIX  = 8'hCB;
	localparam logic [7:0] OP_CALL    = 8'hCD;
	localparam logic [7:0] OP_LDH_N   = 8'hE0;
	localparam logic [7:0] OP_LDH_C   = 8'hE2;
	localparam logic [7:0] OP_ST_NN   = 8'hEA;
	localparam logic [7:0] OP_CP_N    = 8'hFE;

	localparam logic [7:0] CB_RL_C   = 8'h11;
	localparam logic [7:0] CB_RL_A   = 8'h17;
	localparam logic [7:0] CB_BIT7_H = 8'h7C;

	typedef struct packed {
		logic [7:0]  opcode;
		logic [7:0]  operand_low;
		logic [7:0]  operand_high;
		logic [15:0] read_data;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  acc_value;
		logic [7:0]  flag_bits;
		logic [15:0] pair_bc;
		logic [15:0] pair_de;
		logic [15:0] pair_hl;
		logic [15:0] prog_counter;
		logic [15:0] stack_ptr;
		logic [31:0] cycle_total;
		logic [1:0]  write_kind;
		logic [15:0] write_addr;
		logic [15:0] write_data;
		logic        illegal;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  acc;
		logic [7:0]  flags;
		logic [7:0]  b;
		logic [7:0]  c;
		logic [7:0]  d;
		logic [7:0]  e;
		logic [7:0]  h;
		logic [7:0]  l;
		logic [15:0] pc;
		logic [15:0] sp;
		logic [31:0] cyc;
	} arch_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] addr;
		logic [15:0] data;
	} wr_t;

endpackage

`default_nettype wire

### src/sm83_subset_instruction_executor.sv
// The accepted command beat is registered in cmd_s1; its result beat is registered in rsp_q.
// Throughput: one instruction per cycle unless rsp_ready stalls; the whole execute step is one pass from
// the input register to the result register, with the register file updated alongside.
// Reset: arst_n clears A, F, BC, DE, HL, PC, SP and the cycle count to zero and
// empties both stages.
`default_nettype none
`include "sm83_subset_instruction_executor_macros.svh"

module sm83_subset_instruction_executor
	import sm83_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  cmd_valid,
	output logic cmd_ready,
	input  wire  cmd_t cmd,
	output logic rsp_valid,
	input  wire  rsp_ready,
	output rsp_t rsp
);

	cmd_t  cmd_s1;
	logic  valid_s1;
	arch_t arch_q;
	rsp_t  rsp_q;
	logic  rsp_valid_q;

	arch_t arch_nxt;
	wr_t   wr;
	logic  bad;
	logic  advance;
	logic  retire;

	sm83_exec u_exec (
		.cur (arch_q),
		.cmd (cmd_s1),
		.nxt (arch_nxt),
		.wr  (wr),
		.bad (bad)
	);

	assign advance   = !rsp_valid_q || rsp_ready;
	assign retire    = valid_s1 && advance;
	assign cmd_ready = !valid_s1 || advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			arch_q      <= '0;
		end else begin
			if (cmd_ready) begin
				valid_s1 <= cmd_valid;
			end
			if (advance) begin
				rsp_valid_q <= valid_s1;
			end
			if (retire) begin
				arch_q <= arch_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			cmd_s1 <= cmd;
		end
		if (retire) begin
			rsp_q <= '{
				acc_value:    arch_nxt.acc,
				flag_bits:    arch_nxt.flags,
				pair_bc:      {arch_nxt.b, arch_nxt.c},
				pair_de:      {arch_nxt.d, arch_nxt.e},
				pair_hl:      {arch_nxt.h, arch_nxt.l},
				prog_counter: arch_nxt.pc,
				stack_ptr:    arch_nxt.sp,
				cycle_total:  arch_nxt.cyc,
				write_kind:   wr.kind,
				write_addr:   wr.addr,
				write_data:   wr.data,
				illegal:      bad
			};
		end
	end

	`SM83_ASSERT_NOW(a_illegal_no_write, rsp_valid_q && rsp_q.illegal, rsp_q.write_kind == WK_NONE, "illegal beat requests a write")
	`SM83_ASSERT_NEXT(a_illegal_keeps_state, retire && bad, $stable(arch_q), "illegal opcode changed state")
	`SM83_ASSERT_NEXT(a_idle_keeps_state, !retire, $stable(arch_q), "state moved without a retired beat")
	`SM83_ASSERT_NEXT(a_cycle_step, retire, (arch_q.cyc - $past(arch_q.cyc)) <= 32'd4, "cycle count step too large")

endmodule

`default_nettype wire

### src/sm83_exec.sv
`default_nettype none

module sm83_exec
	import sm83_pkg::*;
(
	input  wire arch_t cur,
	input  wire cmd_t  cmd,
	output arch_t nxt,
	output wr_t   wr,
	output logic  bad
);

	always_comb begin
		logic [15:0] nn;
		logic [15:0] disp;
		logic [15:0] pc1;
		logic [15:0] pc_n;
		logic [15:0] hl;
		logic [15:0] tmp;
		logic [7:0]  lo;
		logic [7:0]  res;
		logic [2:0]  cyc_add;
		logic        cin;

		lo      = cmd.operand_low;
		nn      = {cmd.operand_high, lo};
		disp    = {{8{lo[7]}}, lo};
		pc1     = cur.pc + 16'd1;
		pc_n    = pc1;
		hl      = {cur.h, cur.l};
		tmp     = 16'd0;
		res     = 8'd0;
		cin     = cur.flags[4];
		cyc_add = 3'd0;
		nxt     = cur;
		wr      = '0;
		bad     = 1'b0;

		unique case (cmd.opcode)
			OP_NOP: begin
			end
			OP_DEC_B: begin
				res = cur.b - 8'd1;
				nxt.b = res;
				nxt.flags = {res == 8'd0, 1'b1, cur.b[3:0] == 4'd0, cin, 4'd0};
			end
			OP_LD_B_N: begin
				nxt.b = lo;
				pc_n = pc1 + 16'd1;
				cyc_add = 3'd2;
			end
			OP_INC_C: begin
				res = cur.c + 8'd1;
				nxt.c = res;
				nxt.flags = {res == 8'd0, 1'b0, cur.c[3:0] == 4'hF, cin, 4'd0};
			end
			OP_LD_C_N: begin
				nxt.c = lo;
				pc_n = pc1 + 16'd1;
				cyc_add = 3'd2;
			end
			OP_LD_DE: begin
				{nxt.d, nxt.e} = nn;
				pc_n = pc1 + 16'd2;
			end
			OP_INC_DE: begin
				{nxt.d, nxt.e} = {cur.d, cur.e} + 16'd1;
				cyc_add = 3'd1;
			end
			OP_RLA: begin
				nxt.acc = {cur.acc[6:0], cin};
				nxt.flags = {3'd0, cur.acc[7], 4'd0};
				cyc_add = 3'd1;
			end
			OP_LD_A_DE: begin
				nxt.acc = cmd.read_data[7:0];
			end
			OP_JR_NZ: begin
				pc_n = cur.flags[7] ? pc1 + 16'd1 : pc1 + 16'd1 + disp;
			end
			OP_LD_HL: begin
				{nxt.h, nxt.l} = nn;
				pc_n = pc1 + 16'd2;
			end
			OP_LDI: begin
				wr = '{kind: WK_BYTE, addr: hl, data: {8'd0, cur.acc}};
				{nxt.h, nxt.l} = hl + 16'd1;
				cyc_add = 3'd2;
			end
			OP_INC_HL: begin
				{nxt.h, nxt.l} = hl + 16'd1;
				cyc_add = 3'd1;
			end
			OP_JR_Z: begin
				pc_n = cur.flags[7] ? pc1 + 16'd1 + disp : pc1 + 16'd1;
				cyc_add = cur.flags[7] ? 3'd3 : 3'd2;
			end
			OP_LD_SP: begin
				nxt.sp = nn;
				pc_n = pc1 + 16'd2;
			end
			OP_LDD: begin
				wr = '{kind: WK_BYTE, addr: hl, data: {8'd0, cur.acc}};
				{nxt.h, nxt.l} = hl - 16'd1;
			end
			OP_DEC_A: begin
				res = cur.acc - 8'd1;
				nxt.acc = res;
				nxt.flags = {res == 8'd0, 1'b1, cur.acc[3:0] == 4'd0, cin, 4'd0};
				cyc_add = 3'd1;
			end
			OP_LD_A_N: begin
				nxt.acc = lo;
				pc_n = pc1 + 16'd1;
				cyc_add = 3'd2;
			end
			OP_LD_C_A: begin
				nxt.c = cur.acc;
				cyc_add = 3'd1;
			end
			OP_ST_HL: begin
				wr = '{kind: WK_BYTE, addr: hl, data: {8'd0, cur.acc}};
			end
			OP_LD_A_E: begin
				nxt.acc = cur.e;
				cyc_add = 3'd1;
			end
			OP_XOR_A: begin
				nxt.acc = 8'd0;
				nxt.flags = FLAG_Z;
			end
			OP_POP_BC: begin
				{nxt.b, nxt.c} = cmd.read_data;
				nxt.sp = cur.sp + 16'd2;
				cyc_add = 3'd3;
			end
			OP_PUSH_BC: begin
				tmp = cur.sp - 16'd2;
				nxt.sp = tmp;
				wr = '{kind: WK_WORD, addr: tmp, data: {cur.b, cur.c}};
				cyc_add = 3'd3;
			end
			OP_RET: begin
				pc_n = cmd.read_data;
				nxt.sp = cur.sp + 16'd2;
				cyc_add = 3'd3;
			end
			OP_PREFIX: begin
				pc_n = pc1 + 16'd1;
				unique case (lo)
					CB_RL_C: begin
						res = {cur.c[6:0], cin};
						nxt.c = res;
						nxt.flags = {res == 8'd0, 2'd0, cur.c[7], 4'd0};
						cyc_add = 3'd2;
					end
					CB_RL_A: begin
						res = {cur.acc[6:0], cin};
						nxt.acc = res;
						nxt.flags = {res == 8'd0, 2'd0, cur.acc[7], 4'd0};
						cyc_add = 3'd2;
					end
					CB_BIT7_H: begin
						nxt.flags = {~cur.h[7], 1'b0, 1'b1, cin, 4'd0};
					end
					default: begin
						bad = 1'b1;
					end
				endcase
			end
			OP_CALL: begin
				tmp = cur.sp - 16'd2;
				nxt.sp = tmp;
				wr = '{kind: WK_WORD, addr: tmp, data: pc1 + 16'd2};
				pc_n = nn;
			end
			OP_LDH_N: begin
				pc_n = pc1 + 16'd1;
				wr = '{kind: WK_BYTE, addr: HIGH_PAGE | {8'd0, lo}, data: {8'd0, cur.acc}};
			end
			OP_LDH_C: begin
				wr = '{kind: WK_BYTE, addr: HIGH_PAGE | {8'd0, cur.c}, data: {8'd0, cur.acc}};
			end
			OP_ST_NN: begin
				wr = '{kind: WK_BYTE, addr: nn, data: {8'd0, cur.acc}};
				pc_n = pc1 + 16'd2;
				cyc_add = 3'd4;
			end
			OP_CP_N: begin
				nxt.flags = {cur.acc == lo, 1'b1, cur.acc[3:0] < lo[3:0], cur.acc < lo, 4'd0};
				pc_n = pc1 + 16'd1;
				cyc_add = 3'd2;
			end
			default: begin
				bad = 1'b1;
			end
		endcase

		nxt.pc  = bad ? cur.pc : pc_n;
		nxt.cyc = cur.cyc + {29'd0, cyc_add};
	end

endmodule

`default_nettype wire

### dv/sm83_exec_checker.sv
`timescale 1ns / 1ps

module sm83_exec_checker
	import sm83_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  cmd_valid,
	input  wire  cmd_ready,
	input  cmd_t cmd,
	input  wire  rsp_valid,
	input  wire  rsp_ready,
	input  rsp_t rsp,
	output int   mismatches,
	output int   outstanding,
	output int   results_checked
);

	arch_t cpu = '0;
	rsp_t  snapshots_q[$];
	int    fails = 0;
	int    checks = 0;

	initial begin
		mismatches = 0;
		outstanding = 0;
		results_checked = 0;
	end

	function automatic logic [15:0] rotate_carry(input logic [7:0] v, input logic [7:0] f,
			input bit keep_z);
		logic [7:0] r;
		logic [7:0] nf;
		r = {v[6:0], (f & FLAG_C) != 8'h00};
		nf = v[7] ? FLAG_C : 8'h00;
		if (keep_z && r == 8'h00) nf |= FLAG_Z;
		return {nf, r};
	endfunction

	function automatic logic [7:0] dec_flags(input logic [7:0] f, input logic [7:0] prev,
			input logic [7:0] res);
		logic [7:0] nf;
		nf = (f & FLAG_C) | FLAG_N;
		if (res == 8'h00) nf |= FLAG_Z;
		if (prev[3:0] == 4'h0) nf |= FLAG_H;
		return nf;
	endfunction

	// advance the architectural state by one instruction
	function automatic rsp_t step_cpu(input cmd_t c);
		arch_t n;
		wr_t w;
		logic [15:0] nn;
		logic [15:0] disp;
		logic [15:0] pc;
		logic [7:0] t;
		logic bad;
		rsp_t r;
		n = cpu;
		w = '0;
		bad = 1'b0;
		nn = {c.operand_high, c.operand_low};
		disp = {{8{c.operand_low[7]}}, c.operand_low};
		pc = cpu.pc + 16'd1;
		case (c.opcode)
			OP_NOP: ;
			OP_DEC_B: begin
				t = n.b - 8'd1;
				n.flags = dec_flags(n.flags, n.b, t);
				n.b = t;
			end
			OP_LD_B_N: begin
				n.b = c.operand_low;
				pc += 16'd1;
				n.cyc += 32'd2;
			end
			OP_INC_C: begin
				t = n.c + 8'd1;
				n.flags &= FLAG_C;
				if (t == 8'h00) n.flags |= FLAG_Z;
				if (n.c[3:0] == 4'hF) n.flags |= FLAG_H;
				n.c = t;
			end
			OP_LD_C_N: begin
				n.c = c.operand_low;
				pc += 16'd1;
				n.cyc += 32'd2;
			end
			OP_LD_DE: begin
				{n.d, n.e} = nn;
				pc += 16'd2;
			end
			OP_INC_DE: begin
				{n.d, n.e} = {n.d, n.e} + 16'd1;
				n.cyc += 32'd1;
			end
			OP_RLA: begin
				{n.flags, n.acc} = rotate_carry(n.acc, n.flags, 1'b0);
				n.cyc += 32'd1;
			end
			OP_LD_A_DE: n.acc = c.read_data[7:0];
			OP_JR_NZ: begin
				pc += 16'd1;
				if ((n.flags & FLAG_Z) == 8'h00) pc += disp;
			end
			OP_LD_HL: begin
				{n.h, n.l} = nn;
				pc += 16'd2;
			end
			OP_LDI: begin
				w = '{kind: WK_BYTE, addr: {n.h, n.l}, data: {8'h00, n.acc}};
				{n.h, n.l} = {n.h, n.l} + 16'd1;
				n.cyc += 32'd2;
			end
			OP_INC_HL: begin
				{n.h, n.l} = {n.h, n.l} + 16'd1;
				n.cyc += 32'd1;
			end
			OP_JR_Z: begin
				pc += 16'd1;
				n.cyc += 32'd2;
				if ((n.flags & FLAG_Z) != 8'h00) begin
					pc += disp;
					n.cyc += 32'd1;
				end
			end
			OP_LD_SP: begin
				n.sp = nn;
				pc += 16'd2;
			end
			OP_LDD: begin
				w = '{kind: WK_BYTE, addr: {n.h, n.l}, data: {8'h00, n.acc}};
				{n.h, n.l} = {n.h, n.l} - 16'd1;
			end
			OP_DEC_A: begin
				t = n.acc - 8'd1;
				n.flags = dec_flags(n.flags, n.acc, t);
				n.acc = t;
				n.cyc += 32'd1;
			end
			OP_LD_A_N: begin
				n.acc = c.operand_low;
				pc += 16'd1;
				n.cyc += 32'd2;
			end
			OP_LD_C_A: begin
				n.c = n.acc;
				n.cyc += 32'd1;
			end
			OP_ST_HL: w = '{kind: WK_BYTE, addr: {n.h, n.l}, data: {8'h00, n.acc}};
			OP_LD_A_E: begin
				n.acc = n.e;
				n.cyc += 32'd1;
			end
			OP_XOR_A: begin
				n.acc = 8'h00;
				n.flags = FLAG_Z;
			end
			OP_POP_BC: begin
				{n.b, n.c} = c.read_data;
				n.sp += 16'd2;
				n.cyc += 32'd3;
			end
			OP_PUSH_BC: begin
				n.sp -= 16'd2;
				w = '{kind: WK_WORD, addr: n.sp, data: {n.b, n.c}};
				n.cyc += 32'd3;
			end
			OP_RET: begin
				pc = c.read_data;
				n.sp += 16'd2;
				n.cyc += 32'd3;
			end
			OP_PREFIX: begin
				pc += 16'd1;
				case (c.operand_low)
					CB_RL_C: begin
						{n.flags, n.c} = rotate_carry(n.c, n.flags, 1'b1);
						n.cyc += 32'd2;
					end
					CB_RL_A: begin
						{n.flags, n.acc} = rotate_carry(n.acc, n.flags, 1'b1);
						n.cyc += 32'd2;
					end
					CB_BIT7_H: begin
						n.flags = (n.flags & FLAG_C) | FLAG_H;
						if (!n.h[7]) n.flags |= FLAG_Z;
					end
					default: bad = 1'b1;
				endcase
			end
			OP_CALL: begin
				n.sp -= 16'd2;
				w = '{kind: WK_WORD, addr: n.sp, data: pc + 16'd2};
				pc = nn;
			end
			OP_LDH_N: begin
				pc += 16'd1;
				w = '{kind: WK_BYTE, addr: HIGH_PAGE | {8'h00, c.operand_low},
					data: {8'h00, n.acc}};
			end
			OP_LDH_C: w = '{kind: WK_BYTE, addr: HIGH_PAGE | {8'h00, n.c},
				data: {8'h00, n.acc}};
			OP_ST_NN: begin
				w = '{kind: WK_BYTE, addr: nn, data: {8'h00, n.acc}};
				pc += 16'd2;
				n.cyc += 32'd4;
			end
			OP_CP_N: begin
				n.flags = FLAG_N;
				if (n.acc == c.operand_low) n.flags |= FLAG_Z;
				if (n.acc[3:0] < c.operand_low[3:0]) n.flags |= FLAG_H;
				if (n.acc < c.operand_low) n.flags |= FLAG_C;
				pc += 16'd1;
				n.cyc += 32'd2;
			end
			default: bad = 1'b1;
		endcase
		if (!bad) begin
			n.pc = pc;
			cpu = n;
		end else begin
			w = '0;
		end
		r.acc_value = cpu.acc;
		r.flag_bits = cpu.flags;
		r.pair_bc = {cpu.b, cpu.c};
		r.pair_de = {cpu.d, cpu.e};
		r.pair_hl = {cpu.h, cpu.l};
		r.prog_counter = cpu.pc;
		r.stack_ptr = cpu.sp;
		r.cycle_total = cpu.cyc;
		r.write_kind = w.kind;
		r.write_addr = w.addr;
		r.write_data = w.data;
		r.illegal = bad;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			fails++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : watch
		rsp_t want;
		if (arst_n) begin
			if (cmd_valid && cmd_ready)
				snapshots_q.push_back(step_cpu(cmd));
			if (rsp_valid && rsp_ready) begin
				if (snapshots_q.size() == 0) begin
					fails++;
					$display("%0t: result beat with none expected, actual %0h", $time, rsp);
				end else begin
					want = snapshots_q.pop_front();
					checks++;
					check_field("acc_value", 32'(want.acc_value), 32'(rsp.acc_value));
					check_field("flag_bits", 32'(want.flag_bits), 32'(rsp.flag_bits));
					check_field("pair_bc", 32'(want.pair_bc), 32'(rsp.pair_bc));
					check_field("pair_de", 32'(want.pair_de), 32'(rsp.pair_de));
					check_field("pair_hl", 32'(want.pair_hl), 32'(rsp.pair_hl));
					check_field("prog_counter", 32'(want.prog_counter),
						32'(rsp.prog_counter));
					check_field("stack_ptr", 32'(want.stack_ptr), 32'(rsp.stack_ptr));
					check_field("cycle_total", want.cycle_total, rsp.cycle_total);
					check_field("write_kind", 32'(want.write_kind), 32'(rsp.write_kind));
					check_field("write_addr", 32'(want.write_addr), 32'(rsp.write_addr));
					check_field("write_data", 32'(want.write_data), 32'(rsp.write_data));
					check_field("illegal", 32'(want.illegal), 32'(rsp.illegal));
				end
			end
			outstanding <= snapshots_q.size();
			mismatches <= fails;
			results_checked <= checks;
		end
	end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import sm83_pkg::*;

	localparam int RANDOM_ITEMS = 1550;
	localparam int CALM_ITEMS = 150;
	localparam int CYCLE_LIMIT = 500000;

	localparam logic [7:0] OP_UNDEF = 8'hD3;
	localparam logic [7:0] CB_UNDEF = 8'h00;

	localparam logic [7:0] LEGAL_OPS [0:30] = '{
		OP_NOP, OP_DEC_B, OP_LD_B_N, OP_INC_C, OP_LD_C_N, OP_LD_DE, OP_INC_DE, OP_RLA,
		OP_LD_A_DE, OP_JR_NZ, OP_LD_HL, OP_LDI, OP_INC_HL, OP_JR_Z, OP_LD_SP, OP_LDD,
		OP_DEC_A, OP_LD_A_N, OP_LD_C_A, OP_ST_HL, OP_LD_A_E, OP_XOR_A, OP_POP_BC,
		OP_PUSH_BC, OP_RET, OP_PREFIX, OP_CALL, OP_LDH_N, OP_LDH_C, OP_ST_NN, OP_CP_N
	};
	localparam logic [7:0] CB_OPS [0:2] = '{CB_RL_C, CB_RL_A, CB_BIT7_H};

	logic clk;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	int mismatches;
	int outstanding;
	int results_checked;
	int idle_pct = 0;
	int stall_left = 0;
	int cycle_ctr = 0;
	int sent = 0;
	int directed = 0;

	sm83_subset_instruction_executor i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	sm83_exec_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd_ready       (cmd_ready),
		.cmd             (cmd),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.rsp             (rsp),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.results_checked (results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_ctr <= cycle_ctr + 1;
		if (cycle_ctr >= CYCLE_LIMIT) begin
			$display("sm83_subset_instruction_executor: mismatch");
			$finish;
		end
	end

	// stall the result side in bursts of random length while idle_pct is nonzero
	always @(posedge clk) begin
		if (stall_left > 0) begin
			rsp_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_pct != 0 && $urandom_range(99) < idle_pct / 3) begin
			rsp_ready <= 1'b0;
			stall_left <= $urandom_range(13);
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return ($urandom_range(1) == 1) ? 8'h80 : 8'h7F;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic issue(input logic [7:0] op, input logic [7:0] lo, input logic [7:0] hi,
			input logic [15:0] rd);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(14, 1)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= '{opcode: op, operand_low: lo, operand_high: hi, read_data: rd};
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		sent++;
	endtask

	initial begin
		logic [7:0] op;
		logic [7:0] lo;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 20;
		issue(OP_NOP, 8'h00, 8'h00, 16'h0000);
		issue(OP_DEC_B, 8'h00, 8'h00, 16'h0000);
		issue(OP_LD_B_N, 8'h01, 8'h00, 16'h0000);
		issue(OP_DEC_B, 8'h00, 8'h00, 16'h0000);
		issue(OP_LD_C_N, 8'hFF, 8'h00, 16'h0000);
		issue(OP_INC_C, 8'h00, 8'h00, 16'h0000);
		issue(OP_PREFIX, CB_RL_C, 8'h00, 16'h0000);
		issue(OP_LD_DE, 8'hFF, 8'hFF, 16'h0000);
		issue(OP_INC_DE, 8'h00, 8'h00, 16'h0000);
		issue(OP_LD_A_DE, 8'h00, 8'h00, 16'hFFFF);
		issue(OP_XOR_A, 8'h00, 8'h00, 16'h0000);
		issue(OP_LD_A_N, 8'h80, 8'h00, 16'h0000);
		issue(OP_RLA, 8'h00, 8'h00, 16'h0000);
		issue(OP_XOR_A, 8'h00, 8'h00, 16'h0000);
		issue(OP_LD_A_N, 8'h80, 8'h00, 16'h0000);
		issue(OP_PREFIX, CB_RL_A, 8'h00, 16'h0000);
		issue(OP_JR_Z, 8'h80, 8'h00, 16'h0000);
		issue(OP_JR_NZ, 8'h7F, 8'h00, 16'h0000);
		issue(OP_CP_N, 8'hFF, 8'h00, 16'h0000);
		issue(OP_JR_NZ, 8'h7F, 8'h00, 16'h0000);
		issue(OP_JR_Z, 8'h80, 8'h00, 16'h0000);
		issue(OP_LD_HL, 8'hFF, 8'hFF, 16'h0000);
		issue(OP_LDI, 8'h00, 8'h00, 16'h0000);
		issue(OP_LDD, 8'h00, 8'h00, 16'h0000);
		issue(OP_INC_HL, 8'h00, 8'h00, 16'h0000);
		issue(OP_ST_HL, 8'h00, 8'h00, 16'h0000);
		issue(OP_PREFIX, CB_BIT7_H, 8'h00, 16'h0000);
		issue(OP_LD_SP, 8'h00, 8'h00, 16'h0000);
		issue(OP_PUSH_BC, 8'h00, 8'h00, 16'h0000);
		issue(OP_POP_BC, 8'h00, 8'h00, 16'hFFFF);
		issue(OP_CALL, 8'hFF, 8'hFF, 16'h0000);
		issue(OP_RET, 8'h00, 8'h00, 16'h0000);
		issue(OP_DEC_A, 8'h00, 8'h00, 16'h0000);
		issue(OP_LD_C_A, 8'h00, 8'h00, 16'h0000);
		issue(OP_LD_A_E, 8'h00, 8'h00, 16'h0000);
		issue(OP_CP_N, 8'h00, 8'h00, 16'h0000);
		issue(OP_LDH_N, 8'hFF, 8'h00, 16'h0000);
		issue(OP_LDH_C, 8'h00, 8'h00, 16'h0000);
		issue(OP_ST_NN, 8'hFF, 8'hFF, 16'h0000);
		issue(OP_PREFIX, CB_UNDEF, 8'h00, 16'h0000);
		issue(OP_UNDEF, 8'h5A, 8'hA5, 16'h1234);
		directed = sent;

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i >= RANDOM_ITEMS - CALM_ITEMS)
				idle_pct = 0;
			else if (i % 250 == 0)
				case ($urandom_range(3))
					0: idle_pct = 0;
					1: idle_pct = 10;
					2: idle_pct = 30;
					default: idle_pct = 60;
				endcase
			if ($urandom_range(99) < 6)
				op = 8'($urandom_range(255));
			else
				op = LEGAL_OPS[$urandom_range(30)];
			lo = pick_byte();
			if (op == OP_PREFIX && $urandom_range(9) < 8)
				lo = CB_OPS[$urandom_range(2)];
			issue(op, lo, pick_byte(), {pick_byte(), pick_byte()});
		end
		cmd_valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("ran %0d instructions (%0d directed, rest random with idle bursts)",
			sent, directed);
		$display("compared %0d register snapshots field by field", results_checked);
		if (mismatches == 0 && outstanding == 0)
			$display("sm83_subset_instruction_executor: match");
		else
			$display("sm83_subset_instruction_executor: mismatch");
		$finish;
	end

endmodule
